// ----- src/audio_buffer_pool_queue_defines.svh -----
// Assertion macros for the audio buffer pool queue.
// Included by files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef AUDIO_BUFFER_POOL_QUEUE_DEFINES_SVH
`define AUDIO_BUFFER_POOL_QUEUE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ABPQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ABPQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/abpq_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// audio buffer pool queue. No dependencies.
package abpq_pkg;

    localparam int BUF_N  = 4;
    localparam int IDX_W  = 2;
    localparam int CNT_W  = 3;
    localparam int LEN_W  = 20;
    localparam int FB_W   = 18;
    localparam int OFF_W  = 17;
    localparam int KIND_W = 3;
    localparam int OP_W   = 2;

    localparam logic [FB_W-1:0] FRAME_RST = FB_W'(512);

    localparam logic [OP_W-1:0] OP_PRODUCE = 2'd0;
    localparam logic [OP_W-1:0] OP_CONSUME = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [KIND_W-1:0] K_GRANT   = 3'd0;
    localparam logic [KIND_W-1:0] K_REFUSE  = 3'd1;
    localparam logic [KIND_W-1:0] K_SEGMENT = 3'd2;
    localparam logic [KIND_W-1:0] K_NONE    = 3'd3;
    localparam logic [KIND_W-1:0] K_CLEARED = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  buffer_index;
        logic [OFF_W-1:0]  read_offset;
        logic [FB_W-1:0]   byte_count;
        logic [LEN_W-1:0]  unfilled_bytes;
        logic              last;
    } t_result;

    typedef struct packed {
        logic load;   // capture the accepted input transaction
        logic step;   // execute one result step
    } t_cmd;

    typedef struct packed {
        logic             out_free;   // output register can take a result
        logic             step_last;  // current step finishes the item
        logic [CNT_W-1:0] free_cnt;
        logic [CNT_W-1:0] fifo_cnt;
    } t_status;

endpackage

// ----- src/audio_buffer_pool_queue.sv -----
// Audio buffer pool queue: produce, consume and clear items over 4 buffers.
// Produce and clear give one result, registered after the load and one step; a
// consume gives one segment per cycle while the output register has room, up to
// 4, one per buffer queued, or a none result if empty; one item at a time.
// Reset (synchronous, active low): all buffers free, queue empty, frame 512.
module audio_buffer_pool_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [19:0] request_bytes, rest zero
    input  logic [1:0]  i_s_tuser,   // [1:0] operation
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [1:0] buffer_index, [18:2] read_offset,
                                     // [36:19] byte_count, [56:37] unfilled_bytes
    output logic [2:0]  o_m_tuser,   // [2:0] kind
    output logic        o_m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "audio_buffer_pool_queue_defines.svh"

    logic [abpq_pkg::FB_W-1:0] r_frame_bytes;
    abpq_pkg::t_cmd            w_cmd;
    abpq_pkg::t_status         w_status;
    abpq_pkg::t_result         w_out;
    logic                      w_pool_ok;
    logic                      w_single_out;
    logic                      w_in_acc;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= abpq_pkg::FRAME_RST;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_frame_bytes <= pwdata[abpq_pkg::FB_W-1:0];
        end
    end

    assign prdata = paddr[2] ? '0 : 32'(r_frame_bytes);

    abpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    abpq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_op          (i_s_tuser),
        .i_len         (i_s_tdata[abpq_pkg::LEN_W-1:0]),
        .i_frame_bytes (r_frame_bytes),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_out         (w_out)
    );

    assign o_m_tuser = w_out.kind;
    assign o_m_tlast = w_out.last;
    assign o_m_tdata = 64'({w_out.unfilled_bytes, w_out.byte_count,
                            w_out.read_offset, w_out.buffer_index});

    assign w_pool_ok    = (w_status.free_cnt + w_status.fifo_cnt)
                          == abpq_pkg::CNT_W'(abpq_pkg::BUF_N);
    assign w_single_out = o_m_tvalid && (o_m_tuser != abpq_pkg::K_SEGMENT);
    assign w_in_acc     = i_s_tvalid && o_s_tready;

    // every buffer is either free or queued
    `ABPQ_ASSERT_IMP(a_pool_conserved, 1'b1, w_pool_ok, "buffer lost or duplicated")
    // only segments can be followed by more results of the same item
    `ABPQ_ASSERT_IMP(a_single_last, w_single_out, o_m_tlast, "single result not marked last")
    // one item at a time: no back-to-back acceptance
    `ABPQ_ASSERT_NXT(a_one_item, w_in_acc, !o_s_tready, "input accepted while busy")

endmodule

// ----- src/abpq_ctrl.sv -----
// Controller state machine for the audio buffer pool queue.
// Depends on abpq_pkg for the command and status types.
module abpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  abpq_pkg::t_status  i_status,
    output abpq_pkg::t_cmd     o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                // one result per cycle while the output register has room
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.step_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/abpq_dp.sv -----
// Datapath for the audio buffer pool queue: free stack, filled queue,
// per-buffer counts and the output register. Depends on abpq_pkg.
module abpq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  abpq_pkg::t_cmd                i_cmd,
    output abpq_pkg::t_status             o_status,
    input  logic [abpq_pkg::OP_W-1:0]     i_op,
    input  logic [abpq_pkg::LEN_W-1:0]    i_len,
    input  logic [abpq_pkg::FB_W-1:0]     i_frame_bytes,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output abpq_pkg::t_result             o_out
);

    localparam int N   = abpq_pkg::BUF_N;
    localparam int IW  = abpq_pkg::IDX_W;
    localparam int CW  = abpq_pkg::CNT_W;
    localparam int LW  = abpq_pkg::LEN_W;
    localparam int FW  = abpq_pkg::FB_W;
    localparam int OW  = abpq_pkg::OFF_W;

    logic [abpq_pkg::OP_W-1:0] r_op;
    logic [LW-1:0]             r_len;
    logic [IW-1:0]             r_seg;
    logic [IW-1:0]             r_stack [N];
    logic [CW-1:0]             r_free_cnt;
    logic [IW-1:0]             r_fifo [N];
    logic [IW-1:0]             r_head;
    logic [IW-1:0]             r_tail;
    logic [CW-1:0]             r_fifo_cnt;
    logic [FW-1:0]             r_rem [N];
    logic [FW-1:0]             r_size [N];
    logic                      r_out_valid;
    abpq_pkg::t_result         r_out;

    logic [IW-1:0]     w_top;
    logic [IW-1:0]     w_hidx;
    logic [FW-1:0]     w_rem;
    logic [OW-1:0]     w_off;
    logic              w_short;
    logic              w_refuse;
    logic [LW-1:0]     w_len_left;
    logic              w_emit;
    logic              w_last;
    logic              w_grant;
    logic              w_clear;
    logic              w_pop;
    logic              w_push;
    logic              w_rem_wr;
    logic [FW-1:0]     w_rem_val;
    abpq_pkg::t_result w_res;

    assign w_top      = IW'(r_free_cnt - CW'(1));
    assign w_hidx     = r_fifo[r_head];
    assign w_rem      = r_rem[w_hidx];
    assign w_off      = OW'(r_size[w_hidx] - w_rem);
    assign w_short    = LW'(w_rem) < r_len;
    assign w_len_left = r_len - LW'(w_rem);
    assign w_refuse   = (r_free_cnt == '0) || (r_fifo_cnt >= CW'(N));

    always_comb begin
        w_emit    = 1'b1;
        w_last    = 1'b1;
        w_grant   = 1'b0;
        w_clear   = 1'b0;
        w_pop     = 1'b0;
        w_push    = 1'b0;
        w_rem_wr  = 1'b0;
        w_rem_val = w_rem;
        w_res     = '0;
        w_res.last = 1'b1;
        unique case (r_op)
            abpq_pkg::OP_PRODUCE: begin
                if (w_refuse) begin
                    w_res.kind = abpq_pkg::K_REFUSE;
                end else begin
                    w_grant            = 1'b1;
                    w_res.kind         = abpq_pkg::K_GRANT;
                    w_res.buffer_index = r_stack[w_top];
                    w_res.byte_count   = i_frame_bytes;
                end
            end
            abpq_pkg::OP_CONSUME: begin
                if (r_fifo_cnt == '0) begin
                    w_res.kind           = abpq_pkg::K_NONE;
                    w_res.unfilled_bytes = r_len;
                end else begin
                    w_res.kind         = abpq_pkg::K_SEGMENT;
                    w_res.buffer_index = w_hidx;
                    w_res.read_offset  = w_off;
                    w_rem_wr           = 1'b1;
                    if (w_short) begin
                        // whole buffer drained; request continues unless this is the last segment
                        w_pop            = 1'b1;
                        w_push           = 1'b1;
                        w_rem_val        = '0;
                        w_res.byte_count = w_rem;
                        w_last = (r_fifo_cnt == CW'(1)) || (r_seg == IW'(N - 1));
                        w_res.last = w_last;
                        w_res.unfilled_bytes = w_last ? w_len_left : '0;
                    end else begin
                        // len does not exceed rem, so it fits the count width
                        w_pop            = (LW'(w_rem) == r_len);
                        w_push           = w_pop;
                        w_rem_val        = w_rem - r_len[FW-1:0];
                        w_res.byte_count = r_len[FW-1:0];
                    end
                end
            end
            abpq_pkg::OP_CLEAR: begin
                w_clear    = 1'b1;
                w_res.kind = abpq_pkg::K_CLEARED;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cnt <= CW'(N);
            r_head     <= '0;
            r_tail     <= '0;
            r_fifo_cnt <= '0;
            r_seg      <= '0;
            r_op       <= '0;
            for (int i = 0; i < N; i++) begin
                r_stack[i] <= IW'(N - 1 - i);
                r_rem[i]   <= abpq_pkg::FRAME_RST;
                r_size[i]  <= abpq_pkg::FRAME_RST;
            end
        end else if (i_cmd.load) begin
            r_op  <= i_op;
            r_len <= i_len;
            r_seg <= '0;
        end else if (i_cmd.step) begin
            if (w_clear) begin
                r_free_cnt <= CW'(N);
                r_head     <= '0;
                r_tail     <= '0;
                r_fifo_cnt <= '0;
                for (int i = 0; i < N; i++) begin
                    r_stack[i] <= IW'(N - 1 - i);
                    r_rem[i]   <= i_frame_bytes;
                    r_size[i]  <= i_frame_bytes;
                end
            end else if (w_grant) begin
                r_free_cnt                 <= r_free_cnt - CW'(1);
                r_size[r_stack[w_top]]     <= i_frame_bytes;
                r_rem[r_stack[w_top]]      <= i_frame_bytes;
                r_fifo[r_tail]             <= r_stack[w_top];
                r_tail                     <= r_tail + IW'(1);
                r_fifo_cnt                 <= r_fifo_cnt + CW'(1);
            end else begin
                if (w_rem_wr) begin
                    r_rem[w_hidx] <= w_rem_val;
                end
                if (w_pop) begin
                    r_head     <= r_head + IW'(1);
                    r_fifo_cnt <= r_fifo_cnt - CW'(1);
                end
                if (w_push && (r_free_cnt < CW'(N))) begin
                    r_stack[r_free_cnt[IW-1:0]] <= w_hidx;
                    r_free_cnt                  <= r_free_cnt + CW'(1);
                end
                if (w_pop && !w_last) begin
                    r_len <= w_len_left;
                    r_seg <= r_seg + IW'(1);
                end
            end
        end
    end

    // output register decouples result delivery from the next step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out              = r_out;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.step_last = w_last;
    assign o_status.free_cnt  = r_free_cnt;
    assign o_status.fifo_cnt  = r_fifo_cnt;

endmodule

// ----- tb/abpq_result_monitor.sv -----
// Result monitor for the audio buffer pool queue: watches the input, result and APB
// channels, models the buffer pool and compares every result transaction.
// Depends on abpq_pkg.
module abpq_result_monitor #(
    parameter logic [2:0] FRAME_ADDR = 3'd0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [23:0]                   i_s_tdata,
    input  logic [abpq_pkg::OP_W-1:0]     i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [63:0]                   i_m_tdata,
    input  logic [abpq_pkg::KIND_W-1:0]   i_m_tuser,
    input  logic                          i_m_tlast,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [2:0]                    i_paddr,
    input  logic [31:0]                   i_pwdata,
    input  logic [31:0]                   i_prdata,
    input  logic                          i_pready,
    output int                            o_mismatches,
    output int                            o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [abpq_pkg::FB_W-1:0]  frame_bytes;
    logic [abpq_pkg::IDX_W-1:0] free_list [abpq_pkg::BUF_N];
    int                         free_cnt;
    logic [abpq_pkg::IDX_W-1:0] fill_order [abpq_pkg::BUF_N];
    int                         fill_head;
    int                         fill_tail;
    int                         fill_cnt;
    logic [abpq_pkg::FB_W-1:0]  remaining [abpq_pkg::BUF_N];
    logic [abpq_pkg::FB_W-1:0]  size_of [abpq_pkg::BUF_N];
    abpq_pkg::t_result          expected_results [$];
    int                         mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic void reset_pool();
        for (int i = 0; i < abpq_pkg::BUF_N; i++) begin
            free_list[i]  = abpq_pkg::IDX_W'(abpq_pkg::BUF_N - 1 - i);
            fill_order[i] = '0;
            remaining[i]  = frame_bytes;
            size_of[i]    = frame_bytes;
        end
        free_cnt  = abpq_pkg::BUF_N;
        fill_head = 0;
        fill_tail = 0;
        fill_cnt  = 0;
    endfunction

    function automatic void add_result(logic [abpq_pkg::KIND_W-1:0] kind,
                                       logic [abpq_pkg::IDX_W-1:0] idx,
                                       logic [abpq_pkg::OFF_W-1:0] off,
                                       logic [abpq_pkg::FB_W-1:0] cnt,
                                       logic [abpq_pkg::LEN_W-1:0] unf, logic last);
        abpq_pkg::t_result r;
        r.kind           = kind;
        r.buffer_index   = idx;
        r.read_offset    = off;
        r.byte_count     = cnt;
        r.unfilled_bytes = unf;
        r.last           = last;
        expected_results.push_back(r);
    endfunction

    function automatic void release_buffer(logic [abpq_pkg::IDX_W-1:0] idx);
        if (free_cnt < abpq_pkg::BUF_N) begin
            free_list[free_cnt] = idx;
            free_cnt++;
        end
    endfunction

    function automatic void drop_head();
        fill_head = (fill_head + 1) % abpq_pkg::BUF_N;
        fill_cnt--;
    endfunction

    // works out the results of one input transaction and updates the pool
    function automatic void predict_pool_results(logic [abpq_pkg::OP_W-1:0] op,
                                                 logic [abpq_pkg::LEN_W-1:0] len);
        logic [abpq_pkg::LEN_W-1:0] want;
        logic [abpq_pkg::IDX_W-1:0] idx;
        logic [abpq_pkg::FB_W-1:0]  rem;
        logic [abpq_pkg::FB_W-1:0]  off;
        int                         n;
        logic                       done;
        want = len;
        n    = 0;
        done = 1'b0;
        case (op)
            abpq_pkg::OP_PRODUCE: begin
                if (free_cnt == 0 || fill_cnt >= abpq_pkg::BUF_N) begin
                    add_result(abpq_pkg::K_REFUSE, '0, '0, '0, '0, 1'b1);
                end else begin
                    free_cnt--;
                    idx = free_list[free_cnt];
                    size_of[idx]   = frame_bytes;
                    remaining[idx] = frame_bytes;
                    fill_order[fill_tail] = idx;
                    fill_tail = (fill_tail + 1) % abpq_pkg::BUF_N;
                    fill_cnt++;
                    add_result(abpq_pkg::K_GRANT, idx, '0, frame_bytes, '0, 1'b1);
                end
            end
            abpq_pkg::OP_CLEAR: begin
                reset_pool();
                add_result(abpq_pkg::K_CLEARED, '0, '0, '0, '0, 1'b1);
            end
            abpq_pkg::OP_CONSUME: begin
                if (fill_cnt == 0) begin
                    add_result(abpq_pkg::K_NONE, '0, '0, '0, want, 1'b1);
                end else begin
                    while (!done) begin
                        idx = fill_order[fill_head];
                        rem = remaining[idx];
                        off = size_of[idx] - rem;
                        if (rem < want) begin
                            drop_head();
                            want = want - rem;
                            remaining[idx] = '0;
                            release_buffer(idx);
                            done = (fill_cnt == 0 || n + 1 >= abpq_pkg::BUF_N);
                            add_result(abpq_pkg::K_SEGMENT, idx,
                                       off[abpq_pkg::OFF_W-1:0], rem,
                                       done ? want : '0, done);
                            n++;
                        end else begin
                            // a zero-length read frees the head only when it is already empty
                            if (rem == want) begin
                                drop_head();
                                release_buffer(idx);
                            end
                            remaining[idx] = rem - want[abpq_pkg::FB_W-1:0];
                            add_result(abpq_pkg::K_SEGMENT, idx,
                                       off[abpq_pkg::OFF_W-1:0],
                                       want[abpq_pkg::FB_W-1:0], '0, 1'b1);
                            done = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        abpq_pkg::t_result exp_r;
        if (!i_rst_n) begin
            frame_bytes = abpq_pkg::FRAME_RST;
            reset_pool();
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == FRAME_ADDR) begin
                if (i_pwrite) begin
                    frame_bytes = i_pwdata[abpq_pkg::FB_W-1:0];
                end else begin
                    check_field("frame_bytes readback", 32'(frame_bytes), i_prdata);
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: no result expected, got kind %0d data %h", $time,
                             i_m_tuser, i_m_tdata);
                    mismatch_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("kind", 32'(exp_r.kind), 32'(i_m_tuser));
                    check_field("buffer_index", 32'(exp_r.buffer_index), 32'(i_m_tdata[1:0]));
                    check_field("read_offset", 32'(exp_r.read_offset), 32'(i_m_tdata[18:2]));
                    check_field("byte_count", 32'(exp_r.byte_count), 32'(i_m_tdata[36:19]));
                    check_field("unfilled_bytes", 32'(exp_r.unfilled_bytes),
                                32'(i_m_tdata[56:37]));
                    check_field("last", 32'(exp_r.last), 32'(i_m_tlast));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_pool_results(i_s_tuser, i_s_tdata[abpq_pkg::LEN_W-1:0]);
            end
        end
        o_outstanding <= expected_results.size();
    end

endmodule

// ----- tb/tb.sv -----
// Top of the audio buffer pool queue testbench: clock, reset, APB writes and reads,
// produce/consume/clear stimulus with random idling and stalls, and the final verdict.
// Depends on abpq_pkg, audio_buffer_pool_queue and abpq_result_monitor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]                FRAME_BYTES_ADDR = 3'd0;
    localparam logic [abpq_pkg::OP_W-1:0] OP_IGNORED       = 2'd3;
    localparam int                        CYCLE_LIMIT      = 200000;
    localparam int                        PHASE_ITEMS      = 87;

    logic                          i_clk;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [23:0]                   i_s_tdata  = '0;   // [19:0] request_bytes, rest zero
    logic [abpq_pkg::OP_W-1:0]     i_s_tuser  = '0;   // [1:0] operation
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [63:0]                   o_m_tdata;         // [1:0] idx, [18:2] offset,
                                                      // [36:19] count, [56:37] unfilled
    logic [abpq_pkg::KIND_W-1:0]   o_m_tuser;         // [2:0] kind
    logic                          o_m_tlast;
    logic                          psel       = 1'b0;
    logic                          penable    = 1'b0;
    logic                          pwrite     = 1'b0;
    logic [2:0]                    paddr      = '0;
    logic [31:0]                   pwdata     = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    int                            mismatches;
    int                            outstanding;
    int                            idle_pct      = 0;
    int                            stall_pct     = 0;
    int                            cycle_count   = 0;
    logic [abpq_pkg::FB_W-1:0]     frame_setting = abpq_pkg::FRAME_RST;

    audio_buffer_pool_queue dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    abpq_result_monitor #(.FRAME_ADDR(FRAME_BYTES_ADDR)) result_mon (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tuser     (o_m_tuser),
        .i_m_tlast     (o_m_tlast),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("audio_buffer_pool_queue: mismatch");
            $finish;
        end
    end

    // one input transaction; valid stays high across back-to-back items
    task automatic send_item(input logic [abpq_pkg::OP_W-1:0] op,
                             input logic [abpq_pkg::LEN_W-1:0] len);
        if ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {4'b0, len};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // drain all results, then allow for an ignored item still in flight
    task automatic settle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= FRAME_BYTES_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_frame(input logic [abpq_pkg::FB_W-1:0] value);
        settle();
        apb_transfer(1'b1, 32'(value));
        @(posedge i_clk);
        apb_transfer(1'b0, '0);
        frame_setting = value;
    endtask

    function automatic logic [abpq_pkg::LEN_W-1:0] pick_request();
        longint unsigned span;
        span = frame_setting;
        case ($urandom_range(9))
            0: span = 0;
            1: span = $urandom & 32'hF_FFFF;
            2: span = span * $urandom_range(1, 4);
            3: span = span * $urandom_range(1, 3) + 1;
            4: span = (span > 0) ? span * $urandom_range(1, 3) - 1 : 0;
            default: span = $urandom_range(0, 32'(span * 4 + 3));
        endcase
        return (span > 64'hF_FFFF) ? 20'hF_FFFF : span[abpq_pkg::LEN_W-1:0];
    endfunction

    initial begin
        int                        sent;
        int                        roll;
        logic [abpq_pkg::OP_W-1:0] op;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_transfer(1'b0, '0);   // reset value of frame_bytes

        // directed: empty queue, full pool, partial and exact reads, overrun
        send_item(abpq_pkg::OP_CONSUME, 20'd100);
        send_item(abpq_pkg::OP_CONSUME, 20'd0);
        repeat (5) send_item(abpq_pkg::OP_PRODUCE, 20'd0);
        send_item(abpq_pkg::OP_CONSUME, 20'd0);
        send_item(abpq_pkg::OP_CONSUME, 20'd100);
        send_item(abpq_pkg::OP_CONSUME, 20'd412);
        send_item(abpq_pkg::OP_CONSUME, 20'hF_FFFF);
        send_item(OP_IGNORED, 20'hF_FFFF);
        send_item(abpq_pkg::OP_PRODUCE, 20'h5_A5A5);
        send_item(abpq_pkg::OP_CLEAR, 20'hA_5A5A);
        // zero frame size
        set_frame('0);
        send_item(abpq_pkg::OP_PRODUCE, 20'd0);
        send_item(abpq_pkg::OP_PRODUCE, 20'd0);
        send_item(abpq_pkg::OP_CONSUME, 20'd0);
        send_item(abpq_pkg::OP_CONSUME, 20'd5);
        // frame size beyond the offset field
        set_frame('1);
        send_item(abpq_pkg::OP_PRODUCE, 20'd0);
        send_item(abpq_pkg::OP_PRODUCE, 20'd0);
        send_item(abpq_pkg::OP_CONSUME, 20'd200000);
        send_item(abpq_pkg::OP_CONSUME, 20'hF_FFFF);
        send_item(abpq_pkg::OP_CLEAR, 20'd0);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    set_frame(abpq_pkg::FB_W'(4));
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    set_frame(abpq_pkg::FB_W'($urandom_range(5, 96)));
                    idle_pct  = 70;
                    stall_pct = 0;
                end
                2: begin
                    set_frame(abpq_pkg::FB_W'(131072));
                    idle_pct  = 0;
                    stall_pct = 70;
                end
                default: begin
                    set_frame(abpq_pkg::FB_W'($urandom_range(4, 40)));
                    idle_pct  = 31;
                    stall_pct = 31;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                roll = $urandom_range(99);
                if (roll < 40)      op = abpq_pkg::OP_PRODUCE;
                else if (roll < 86) op = abpq_pkg::OP_CONSUME;
                else if (roll < 93) op = abpq_pkg::OP_CLEAR;
                else                op = OP_IGNORED;
                send_item(op, (op == abpq_pkg::OP_CONSUME) ? pick_request() : 20'($urandom));
                sent++;
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("audio_buffer_pool_queue: match");
        end else begin
            $display("audio_buffer_pool_queue: mismatch");
        end
        $finish;
    end

endmodule
